### design/dnps_pkg.sv
// Shared types and constants of the delayed nozzle pulse scheduler.
package dnps_pkg;

  // Default sizes
  localparam int NOZZLES_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  // Fixed field widths
  localparam int NOZ_MAX   = 4;
  localparam int NOZ_W     = 2;
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W   = NOZ_W + TIME_W;

  // Reset values of the configuration registers
  localparam logic [MS_W-1:0] OPEN_DUR_RST = 16'd100;
  localparam logic            POL_RST      = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_0  = 3'd0,
    CFG_DELAY_1  = 3'd1,
    CFG_DELAY_2  = 3'd2,
    CFG_DELAY_3  = 3'd3,
    CFG_OPEN_DUR = 3'd4,
    CFG_POLARITY = 3'd5
  } cfg_idx_e;

  // Request item codes
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_ENQUEUE = 1'b1;

  // Input item
  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] now_ms;
    logic [NOZ_W-1:0]  nozzle_num;
    logic [TIME_W-1:0] request_ms;
  } req_t;

  // Result item
  typedef struct packed {
    logic [NOZ_MAX-1:0] relay_levels;
    logic [NOZ_MAX-1:0] open_mask;
    logic               opened_valid;
    logic [NOZ_W-1:0]   opened_nozzle;
    logic [CNT_W-1:0]   pending_count;
    logic               dropped;
  } res_t;

endpackage

### design/dnps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/delayed_nozzle_pulse_scheduler.sv
// An enqueue item goes straight to S_FIN, which registers its result.
// A tick sweeps the stamp RAM to close expired nozzles (S_CLOSE), scans up to
// min(NOZZLES,fill) entries of the queue RAM (S_SCAN), moves up the entries
// after a removal (S_SH_RD, S_SH_WR) and posts the result (S_FIN); one item at a time.
// The result strobe done_o lasts one cycle and the receiver cannot stall it.
// Reset is asynchronous: nozzles closed, queue empty, registers at defaults.
module delayed_nozzle_pulse_scheduler #(
  parameter int NOZZLES     = dnps_pkg::NOZZLES_DEF,
  parameter int QUEUE_DEPTH = dnps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  dnps_pkg::req_t                      req_i,
  output logic                                done_o,
  output dnps_pkg::res_t                      res_o,
  input  logic                                cfg_we_i,
  input  logic [dnps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dnps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int NAW = (NOZZLES > 1) ? $clog2(NOZZLES) : 1;
  localparam int NCW = $clog2(NOZZLES + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [dnps_pkg::NOZ_MAX-1:0] NOZ_MASK =
    dnps_pkg::NOZ_MAX'((32'd1 << NOZZLES) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } state_e;

  // Configuration registers
  logic [dnps_pkg::MS_W-1:0] delay_q [dnps_pkg::NOZ_MAX];
  logic [dnps_pkg::MS_W-1:0] dur_q;
  logic                      pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < dnps_pkg::NOZ_MAX; n++) begin
        delay_q[n] <= '0;
      end
      dur_q <= dnps_pkg::OPEN_DUR_RST;
      pol_q <= dnps_pkg::POL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dnps_pkg::CFG_DELAY_0:  delay_q[0] <= cfg_data_i;
        dnps_pkg::CFG_DELAY_1:  delay_q[1] <= cfg_data_i;
        dnps_pkg::CFG_DELAY_2:  delay_q[2] <= cfg_data_i;
        dnps_pkg::CFG_DELAY_3:  delay_q[3] <= cfg_data_i;
        dnps_pkg::CFG_OPEN_DUR: dur_q      <= cfg_data_i;
        dnps_pkg::CFG_POLARITY: pol_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  state_e                         state_q;
  logic [NCW-1:0]                 ncnt_q;
  logic [QCW-1:0]                 pos_q;
  logic [QCW-1:0]                 fill_q;
  logic [dnps_pkg::NOZ_MAX-1:0]   flags_q;
  logic [dnps_pkg::TIME_W-1:0]    now_q;
  logic                           opened_q;
  logic [dnps_pkg::NOZ_W-1:0]     opened_noz_q;
  logic                           dropped_q;
  logic                           done_q;
  dnps_pkg::res_t                 res_q;

  // RAM ports
  logic                           q_we;
  logic [QAW-1:0]                 q_waddr;
  logic [dnps_pkg::ENTRY_W-1:0]   q_wdata;
  logic [QAW-1:0]                 q_raddr;
  logic [dnps_pkg::ENTRY_W-1:0]   q_rdata;
  logic                           st_we;
  logic [NAW-1:0]                 st_waddr;
  logic [NAW-1:0]                 st_raddr;
  logic [dnps_pkg::TIME_W-1:0]    st_rdata;

  logic                           accept;
  logic                           noz_ok;
  logic                           full;
  logic [QCW-1:0]                 limit;
  logic [QCW-1:0]                 pos_nx;
  logic [NAW-1:0]                 close_idx;
  logic                           expired;
  logic [dnps_pkg::NOZ_W-1:0]     ent_noz;
  logic [dnps_pkg::TIME_W-1:0]    ent_when;
  logic                           hit;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign noz_ok = (32'(req_i.nozzle_num) < NOZZLES);
  assign full   = (fill_q == QCW'(QUEUE_DEPTH));
  assign pos_nx = pos_q + QCW'(1);

  // Scan covers the first min(NOZZLES, fill) entries
  assign limit = (32'(fill_q) < NOZZLES) ? fill_q : QCW'(NOZZLES);

  // Close check on the stamp read in the previous cycle
  assign close_idx = NAW'(ncnt_q - NCW'(1));
  assign expired   = flags_q[close_idx] &&
                     ((now_q - st_rdata) >= {16'b0, dur_q});

  // Ready check on the queue entry read in the previous cycle
  assign ent_noz  = q_rdata[dnps_pkg::ENTRY_W-1:dnps_pkg::TIME_W];
  assign ent_when = q_rdata[dnps_pkg::TIME_W-1:0];
  assign hit      = (now_q - ent_when) >= {16'b0, delay_q[ent_noz]};

  // Queue RAM access: append on enqueue, move up on removal
  always_comb begin
    q_we    = 1'b0;
    q_waddr = fill_q[QAW-1:0];
    q_wdata = {req_i.nozzle_num, req_i.request_ms};
    q_raddr = '0;
    case (state_q)
      S_IDLE: begin
        q_we = accept && (req_i.req_type == dnps_pkg::REQ_ENQUEUE) && noz_ok && !full;
      end
      S_SCAN: begin
        if (pos_q < limit) begin
          q_raddr = pos_q[QAW-1:0];
        end
      end
      S_SH_RD: begin
        if (pos_nx < fill_q) begin
          q_raddr = pos_nx[QAW-1:0];
        end
      end
      S_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = pos_q[QAW-1:0];
        q_wdata = q_rdata;
      end
      default: ;
    endcase
  end

  // Stamp RAM access: sweep on close, write on open
  assign st_raddr = (32'(ncnt_q) < NOZZLES) ? ncnt_q[NAW-1:0] : '0;
  assign st_we    = (state_q == S_SCAN) && (pos_q != '0) && hit;
  assign st_waddr = NAW'(ent_noz);

  dnps_ram #(
    .WIDTH (dnps_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  dnps_ram #(
    .WIDTH (dnps_pkg::TIME_W),
    .DEPTH (NOZZLES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (now_q),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ncnt_q       <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      flags_q      <= '0;
      now_q        <= '0;
      opened_q     <= 1'b0;
      opened_noz_q <= '0;
      dropped_q    <= 1'b0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            opened_q     <= 1'b0;
            opened_noz_q <= '0;
            dropped_q    <= 1'b0;
            if (req_i.req_type == dnps_pkg::REQ_ENQUEUE) begin
              if (noz_ok) begin
                if (full) begin
                  dropped_q <= 1'b1;
                end else begin
                  fill_q <= fill_q + QCW'(1);
                end
              end
              state_q <= S_FIN;
            end else begin
              now_q   <= req_i.now_ms;
              ncnt_q  <= '0;
              state_q <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if ((ncnt_q != '0) && expired) begin
            flags_q[close_idx] <= 1'b0;
          end
          if (ncnt_q == NCW'(NOZZLES)) begin
            pos_q   <= '0;
            state_q <= S_SCAN;
          end else begin
            ncnt_q <= ncnt_q + NCW'(1);
          end
        end
        S_SCAN: begin
          if ((pos_q != '0) && hit) begin
            flags_q[ent_noz] <= 1'b1;
            opened_q         <= 1'b1;
            opened_noz_q     <= ent_noz;
            pos_q            <= pos_q - QCW'(1);
            state_q          <= S_SH_RD;
          end else if (pos_q == limit) begin
            state_q <= S_FIN;
          end else begin
            pos_q <= pos_nx;
          end
        end
        S_SH_RD: begin
          if (pos_nx < fill_q) begin
            state_q <= S_SH_WR;
          end else begin
            fill_q  <= fill_q - QCW'(1);
            state_q <= S_FIN;
          end
        end
        S_SH_WR: begin
          pos_q   <= pos_nx;
          state_q <= S_SH_RD;
        end
        S_FIN: begin
          res_q.relay_levels  <= (flags_q ^ {dnps_pkg::NOZ_MAX{~pol_q}}) & NOZ_MASK;
          res_q.open_mask     <= flags_q & NOZ_MASK;
          res_q.opened_valid  <= opened_q;
          res_q.opened_nozzle <= opened_noz_q;
          res_q.pending_count <= dnps_pkg::CNT_W'(fill_q);
          res_q.dropped       <= dropped_q;
          done_q              <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### design/dnps_checker.sv
// Port-level checker of the delayed nozzle pulse scheduler and its bind.
module dnps_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input dnps_pkg::res_t  res_o
);

  // An accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Busy ends exactly when the result is posted
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result pulse is one cycle wide and shown while idle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy ##1 !done_o))
    else $error("result strobe malformed");

  // Nothing opened means nozzle field zero; a dropped enqueue opens nothing
  a_open_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.opened_valid || (res_o.opened_nozzle == '0)) &&
                !(res_o.dropped && res_o.opened_valid)))
    else $error("inconsistent result fields");

endmodule

bind delayed_nozzle_pulse_scheduler dnps_checker u_dnps_checker (.*);
